// File: hdl/cogen_pkg.sv
// Shared types, constants and the panel wiring table for the circle outline generator.
`timescale 1ns / 1ps
package cogen_pkg;

  localparam int GRID_WIDTH  = 8;
  localparam int GRID_HEIGHT = 8;
  localparam int RADIUS_MAX  = 8;
  localparam int MAX_ITERS   = 16;

  localparam logic [5:0] HIDDEN_LED = 6'd46;
  localparam logic [3:0] RADIUS_SAT = 4'(RADIUS_MAX);
  localparam logic [3:0] LAST_ITER  = 4'(MAX_ITERS - 1);
  localparam logic [1:0] LAST_PHASE = 2'd3;

  // Physical LED for each grid position, indexed by {row, column}.
  localparam logic [5:0] WIRING [64] = '{
    6'd0, 6'd8, 6'd46, 6'd51, 6'd55, 6'd59, 6'd30, 6'd38,
    6'd1, 6'd9, 6'd16, 6'd52, 6'd56, 6'd27, 6'd31, 6'd39,
    6'd2, 6'd10, 6'd17, 6'd19, 6'd23, 6'd28, 6'd32, 6'd40,
    6'd3, 6'd11, 6'd18, 6'd20, 6'd24, 6'd29, 6'd33, 6'd41,
    6'd4, 6'd12, 6'd47, 6'd21, 6'd25, 6'd60, 6'd34, 6'd42,
    6'd5, 6'd13, 6'd48, 6'd22, 6'd26, 6'd61, 6'd35, 6'd43,
    6'd6, 6'd14, 6'd49, 6'd53, 6'd57, 6'd62, 6'd36, 6'd44,
    6'd7, 6'd15, 6'd50, 6'd54, 6'd58, 6'd63, 6'd37, 6'd45
  };

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       step;
    logic       last;
    logic [1:0] phase;
  } cogen_cmd_t;

  typedef struct packed {
    logic x_more;
  } cogen_stat_t;

endpackage

// File: hdl/circle_outline_pixel_generator.sv
// Top level of the circle outline pixel generator.
`timescale 1ns / 1ps
//
//  channel   handshake                  payload
//  --------  -------------------------  ---------------------------------------------
//  request   start & !busy              in_center_x, in_center_y, in_radius,
//                                        in_colour_in
//  result    out_strobe (one cycle)     out_led_index, out_colour_out, out_last_point
//
// A request runs the midpoint circle walk from x = -r, y = 0 until x reaches 0,
// four points per iteration, one point per cycle, at most 64 points (radius
// saturates at 8, and the walk stops after 16 iterations). The controller's
// phase and iteration counters bound the walk, and it returns to idle with busy
// low after each walk, so a new request is taken only once the current walk
// has ended.
// Each result is registered before it shows on the outputs; busy drops in the
// cycle after the last point, so a new request may be taken while that last
// result is on the ports.
// Reset is synchronous and active low; it idles the controller and drops the
// strobe. The receiver cannot stall, so nothing waits on the output side.
module circle_outline_pixel_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_center_x,
  input  logic [2:0]  in_center_y,
  input  logic [3:0]  in_radius,
  input  logic [23:0] in_colour_in,
  output logic        out_strobe,
  output logic [5:0]  out_led_index,
  output logic [23:0] out_colour_out,
  output logic        out_last_point
);
  import cogen_pkg::*;

  // Commands flow controller -> datapath, status flows back.
  cogen_cmd_t  cmd;
  cogen_stat_t stat;

  // Sequence the walk: load on an accepted request, emit one point a cycle,
  // advance the walk on the fourth point, stop on the last one.
  cogen_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Hold centre, colour and walk state; map each point and register the result.
  cogen_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_colour_in   (in_colour_in),
    .out_strobe     (out_strobe),
    .out_led_index  (out_led_index),
    .out_colour_out (out_colour_out),
    .out_last_point (out_last_point)
  );

endmodule

// File: hdl/cogen_ctrl.sv
// Controller: walk sequencing, point phase and iteration count.
`timescale 1ns / 1ps
module cogen_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cogen_pkg::cogen_stat_t stat,
  output cogen_pkg::cogen_cmd_t  cmd
);
  import cogen_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] iter_r, iter_nxt;
  logic       last_pt;

  assign last_pt = (state_r == ST_WALK) && (phase_r == LAST_PHASE) &&
                   (!stat.x_more || (iter_r == LAST_ITER));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (last_pt) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    phase_nxt = phase_r;
    iter_nxt  = iter_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load  = start;
        phase_nxt = '0;
        iter_nxt  = '0;
      end
      ST_WALK: begin
        cmd.emit  = 1'b1;
        cmd.phase = phase_r;
        cmd.last  = last_pt;
        cmd.step  = (phase_r == LAST_PHASE);
        phase_nxt = last_pt ? 2'd0 : phase_r + 2'd1;
        if (phase_r == LAST_PHASE) iter_nxt = last_pt ? 4'd0 : iter_r + 4'd1;
      end
      default: begin
        phase_nxt = '0;
        iter_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      iter_r  <= iter_nxt;
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last |=> !busy)
    else $error("walk did not end after last point");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !cmd.last |=> busy)
    else $error("walk ended before last point");

  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (phase_r == 2'd0) && (iter_r == 4'd0))
    else $error("counters not cleared while idle");

endmodule

// File: hdl/cogen_dp.sv
// Datapath: walk registers, error-term update, point mapping and output register.
`timescale 1ns / 1ps
module cogen_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cogen_pkg::cogen_cmd_t  cmd,
  output cogen_pkg::cogen_stat_t stat,
  input  logic [2:0]             in_center_x,
  input  logic [2:0]             in_center_y,
  input  logic [3:0]             in_radius,
  input  logic [23:0]            in_colour_in,
  output logic                   out_strobe,
  output logic [5:0]             out_led_index,
  output logic [23:0]            out_colour_out,
  output logic                   out_last_point
);
  import cogen_pkg::*;

  logic [2:0]         cx_r, cy_r;
  logic signed [4:0]  x_r, x1;
  logic [4:0]         y_r, y1;
  logic signed [9:0]  e_r, e1, e2;
  logic [23:0]        colour_r;
  logic [3:0]         r_sat;
  logic               y_up, x_up;
  logic signed [6:0]  cxs, cys, xs, ys, px, py;
  logic [5:0]         led;

  logic        strobe_r;
  logic [5:0]  led_r;
  logic [23:0] colour_out_r;
  logic        last_r;

  assign r_sat = (in_radius > RADIUS_SAT) ? RADIUS_SAT : in_radius;

  // One step of the error-term walk; the x test checks the old e against x and the updated e against the updated y.
  always_comb begin
    y_up = (e_r <= $signed({5'b0, y_r}));
    y1   = y_up ? y_r + 5'd1 : y_r;
    e1   = y_up ? e_r + $signed({4'b0, y1, 1'b1}) : e_r;
    x_up = (e_r > $signed({{5{x_r[4]}}, x_r})) || (e1 > $signed({5'b0, y1}));
    x1   = x_up ? x_r + 5'sd1 : x_r;
    e2   = x_up ? e1 + $signed({{4{x1[4]}}, x1, 1'b1}) : e1;
  end

  assign stat.x_more = x1[4];

  // Pick the point of this phase and map it onto the panel.
  always_comb begin
    cxs = $signed({4'b0, cx_r});
    cys = $signed({4'b0, cy_r});
    xs  = $signed({{2{x_r[4]}}, x_r});
    ys  = $signed({2'b0, y_r});
    case (cmd.phase)
      2'd0:    begin px = cxs + xs; py = cys - ys; end
      2'd1:    begin px = cxs - xs; py = cys + ys; end
      2'd2:    begin px = cxs + ys; py = cys + xs; end
      2'd3:    begin px = cxs - ys; py = cys - xs; end
      default: begin px = cxs;      py = cys;      end
    endcase
    if ((px[6:3] != 4'd0) || (py[6:3] != 4'd0)) led = HIDDEN_LED;
    else led = WIRING[{py[2:0], px[2:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r     <= in_center_x;
      cy_r     <= in_center_y;
      colour_r <= in_colour_in;
      x_r      <= -$signed({1'b0, r_sat});
      y_r      <= '0;
      e_r      <= 10'sd2 - $signed({5'b0, r_sat, 1'b0});
    end else if (cmd.step) begin
      x_r <= x1;
      y_r <= y1;
      e_r <= e2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      led_r        <= led;
      colour_out_r <= colour_r;
      last_r       <= cmd.last;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_led_index  = led_r;
  assign out_colour_out = colour_out_r;
  assign out_last_point = last_r;

endmodule

// File: tb/circle_outline_pixel_generator_test.sv
// Self-checking testbench for the circle outline pixel generator.
`timescale 1ns / 1ps

module circle_outline_pixel_generator_test;
  import cogen_pkg::*;

  // Run length and timing knobs.
  localparam int RANDOM_REQUESTS = 150;
  localparam int QUIET_LIMIT     = 1000; // cycles with no request and no result taken
  localparam int IDLE_PERCENT    = 27;
  localparam int MAX_GAP         = 70;   // long enough to land anywhere in a 64-point walk
  localparam int DRAIN_TAIL      = 8;    // covers the output register, plus margin

  // One circle request. has_led marks a row whose four points are typed in by hand.
  typedef struct packed {
    logic [2:0]  cx;
    logic [2:0]  cy;
    logic [3:0]  rad;
    logic [23:0] colour;
    logic        has_led;
    logic [5:0]  led;
  } circle_req_t;

  // One painted pixel as it should appear on the result ports.
  typedef struct packed {
    logic [5:0]  led;
    logic [23:0] colour;
    logic        last_pt;
  } pixel_t;

  // Directed requests. Zero-radius rows put all four points on the centre LED,
  // so their LED index is read straight off the wiring table; the rest cover
  // the corners, off-grid spill, the largest radius and saturation above it,
  // and go through the predictor.
  localparam circle_req_t DIRECTED_CIRCLES [20] = '{
    '{3'd0, 3'd0, 4'd0,  24'h000000, 1'b1, 6'd0},
    '{3'd7, 3'd7, 4'd0,  24'hFFFFFF, 1'b1, 6'd45},
    '{3'd2, 3'd0, 4'd0,  24'hAAAAAA, 1'b1, 6'd46},
    '{3'd7, 3'd0, 4'd0,  24'h555555, 1'b1, 6'd38},
    '{3'd0, 3'd7, 4'd0,  24'h123456, 1'b1, 6'd7},
    '{3'd3, 3'd4, 4'd1,  24'hFF0000, 1'b0, 6'd0},
    '{3'd3, 3'd3, 4'd8,  24'h00FF00, 1'b0, 6'd0},
    '{3'd4, 3'd4, 4'd8,  24'h0000FF, 1'b0, 6'd0},
    '{3'd0, 3'd0, 4'd8,  24'hFFFFFF, 1'b0, 6'd0},
    '{3'd7, 3'd7, 4'd7,  24'h000000, 1'b0, 6'd0},
    '{3'd3, 3'd3, 4'd9,  24'hA5A5A5, 1'b0, 6'd0},
    '{3'd4, 3'd3, 4'd15, 24'h5A5A5A, 1'b0, 6'd0},
    '{3'd0, 3'd7, 4'd15, 24'hF0F0F0, 1'b0, 6'd0},
    '{3'd7, 3'd0, 4'd4,  24'h0F0F0F, 1'b0, 6'd0},
    '{3'd5, 3'd2, 4'd3,  24'hC3C3C3, 1'b0, 6'd0},
    '{3'd2, 3'd5, 4'd2,  24'h3C3C3C, 1'b0, 6'd0},
    '{3'd1, 3'd6, 4'd5,  24'h800001, 1'b0, 6'd0},
    '{3'd6, 3'd1, 4'd6,  24'h7FFFFE, 1'b0, 6'd0},
    '{3'd3, 3'd4, 4'd10, 24'hDEADBE, 1'b0, 6'd0},
    '{3'd4, 3'd3, 4'd12, 24'h13579B, 1'b0, 6'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_center_x = '0;
  logic [2:0]  in_center_y = '0;
  logic [3:0]  in_radius = '0;
  logic [23:0] in_colour_in = '0;
  logic        out_strobe;
  logic [5:0]  out_led_index;
  logic [23:0] out_colour_out;
  logic        out_last_point;

  pixel_t pending_pixels [$];   // pixels still owed by the block, oldest first
  int     mismatches = 0;
  int     quiet_cycles = 0;

  circle_outline_pixel_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_radius      (in_radius),
    .in_colour_in   (in_colour_in),
    .out_strobe     (out_strobe),
    .out_led_index  (out_led_index),
    .out_colour_out (out_colour_out),
    .out_last_point (out_last_point)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Map a grid point to its physical LED; anything off the 8x8 panel goes to
  // the hidden LED.
  function automatic logic [5:0] panel_led(int px, int py);
    if (px < 0 || py < 0 || px >= GRID_WIDTH || py >= GRID_HEIGHT) return HIDDEN_LED;
    return WIRING[py * GRID_WIDTH + px];
  endfunction

  // Walk the midpoint circle for one request and queue the pixels it paints.
  // Coordinates for the iteration are captured first, then the error term is
  // advanced, so the loop exit is known before the fourth point is queued and
  // the last flag can ride on it.
  function automatic void trace_circle(logic [2:0] cx, logic [2:0] cy,
                                       logic [3:0] rad_in, logic [23:0] colour);
    int  rad, ox, oy, x, y, err, prev, iters;
    int  px [4];
    int  py [4];
    bit  done;
    rad   = (int'(rad_in) > RADIUS_MAX) ? RADIUS_MAX : int'(rad_in);
    ox    = int'(cx);
    oy    = int'(cy);
    x     = -rad;
    y     = 0;
    err   = 2 - 2 * rad;
    iters = 0;
    do begin
      px = '{ox + x, ox - x, ox + y, ox - y};
      py = '{oy - y, oy + y, oy + x, oy - x};
      prev = err;
      if (prev <= y) begin
        y++;
        err += 2 * y + 1;
      end
      if (prev > x || err > y) begin
        x++;
        err += 2 * x + 1;
      end
      iters++;
      done = !(x < 0 && iters < MAX_ITERS);
      for (int k = 0; k < 4; k++) begin
        pending_pixels.push_back(pixel_t'{panel_led(px[k], py[k]), colour, done && k == 3});
      end
    end while (!done);
  endfunction

  // Present one request and hold it until the block takes it. An optional
  // random gap first drops start, so the request lands at an arbitrary point
  // of the walk in progress. Without a gap start stays high from the previous
  // request, so it gets a single assignment in this time step.
  task automatic issue_request(circle_req_t rq, bit may_idle);
    int gap;
    if (may_idle && $urandom_range(99) < IDLE_PERCENT) begin
      gap = $urandom_range(1, MAX_GAP);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_center_x  <= rq.cx;
    in_center_y  <= rq.cy;
    in_radius    <= rq.rad;
    in_colour_in <= rq.colour;
    start        <= 1'b1;
    // Accepted at the first edge that sees busy low.
    do @(posedge clk); while (busy);
    if (rq.has_led) begin
      for (int k = 0; k < 4; k++) begin
        pending_pixels.push_back(pixel_t'{rq.led, rq.colour, k == 3});
      end
    end else begin
      trace_circle(rq.cx, rq.cy, rq.rad, rq.colour);
    end
  endtask

  // Drop start and hold off until every owed pixel has come out.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  initial begin : stimulus
    circle_req_t rq;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table first; drain once in the middle so a request also
    // arrives with the block fully idle.
    foreach (DIRECTED_CIRCLES[i]) begin
      if (i == 5) drain_results();
      issue_request(DIRECTED_CIRCLES[i], 1'b1);
    end
    drain_results();

    // Random requests. The full 4-bit radius range is used so saturation is hit
    // often; requests 40 to 89 go back to back with no idling.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 100) drain_results();
      rq.cx      = 3'($urandom_range(7));
      rq.cy      = 3'($urandom_range(7));
      rq.rad     = 4'($urandom_range(15));
      rq.colour  = 24'($urandom);
      rq.has_led = 1'b0;
      rq.led     = '0;
      issue_request(rq, !(n >= 40 && n < 90));
    end
    start <= 1'b0;

    // Wait out the remaining pixels, then a short tail to catch strays.
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Check every strobed pixel against the oldest one owed.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_strobe) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, got led_index %0d colour %06h last %0b",
                 $time, out_led_index, out_colour_out, out_last_point);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_led_index !== want.led) begin
          $display("%0t: led_index expected %0d, got %0d", $time, want.led, out_led_index);
          mismatches++;
        end
        if (out_colour_out !== want.colour) begin
          $display("%0t: colour_out expected %06h, got %06h",
                   $time, want.colour, out_colour_out);
          mismatches++;
        end
        if (out_last_point !== want.last_pt) begin
          $display("%0t: last_point expected %0b, got %0b",
                   $time, want.last_pt, out_last_point);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: advance on cycles where neither a request nor a pixel is taken.
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: files.f
hdl/cogen_pkg.sv
hdl/cogen_ctrl.sv
hdl/cogen_dp.sv
hdl/circle_outline_pixel_generator.sv
tb/circle_outline_pixel_generator_test.sv
